>>> hw/rtl/ttl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_pkg
// shared types and constants of the text token lexer
// ----------------------------------------------------------------------------
package ttl_pkg;

  // input beat: one character of the stream or an end marker
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_beat_t;

  // result beat: one token character or the end status
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] token_kind;
    logic       first_of_token;
    logic       last_of_token;
    logic       is_status;
    logic       end_status;
  } out_beat_t;

  // lexer modes; codes 6 and 7 act as between tokens
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_LINE    = 3'd2,
    MODE_BLOCK   = 3'd3,
    MODE_BARE    = 3'd4,
    MODE_QUOTED  = 3'd5
  } lex_mode_t;

  localparam logic [1:0] KIND_BARE   = 2'd0;
  localparam logic [1:0] KIND_BRACE  = 2'd1;
  localparam logic [1:0] KIND_QUOTED = 2'd2;

  localparam logic END_CLEAN        = 1'b0;
  localparam logic END_UNTERMINATED = 1'b1;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // result queue: room for two results per item plus two in flight
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

endpackage
`default_nettype wire

>>> hw/rtl/ttl_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_step
// lexer state registers and the per-byte next-state and result logic
// ----------------------------------------------------------------------------
module ttl_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire ttl_pkg::in_beat_t beat,
  output logic [1:0]             res_cnt,
  output ttl_pkg::out_beat_t     res0,
  output ttl_pkg::out_beat_t     res1
);

  ttl_pkg::lex_mode_t lex_mode, lex_mode_next;
  logic [7:0]         held_char, held_char_next;
  logic               held_is_first, held_is_first_next;
  logic               star_seen, star_seen_next;
  logic               escape_pending, escape_pending_next;

  logic [7:0] c;
  logic       c_space;
  logic       c_brace;
  logic       do_bare;
  logic [7:0] bare_hc;
  logic       bare_hf;

  assign c       = beat.in_byte;
  assign c_space = (c == ttl_pkg::CH_SPACE) || (c == ttl_pkg::CH_TAB) ||
                   (c == ttl_pkg::CH_NL) || (c == ttl_pkg::CH_VT) ||
                   (c == ttl_pkg::CH_FF) || (c == ttl_pkg::CH_CR);
  assign c_brace = (c == ttl_pkg::CH_LBRACE) || (c == ttl_pkg::CH_RBRACE);

  always_comb begin
    lex_mode_next       = lex_mode;
    held_char_next      = held_char;
    held_is_first_next  = held_is_first;
    star_seen_next      = star_seen;
    escape_pending_next = escape_pending;
    res_cnt             = 2'd0;
    res0                = '0;
    res1                = '0;
    do_bare             = 1'b0;
    bare_hc             = held_char;
    bare_hf             = held_is_first;

    if (beat.end_of_input) begin
      // flush held character, then the status beat
      if (lex_mode == ttl_pkg::MODE_SLASH || lex_mode == ttl_pkg::MODE_BARE) begin
        res0.out_byte       = (lex_mode == ttl_pkg::MODE_SLASH) ? ttl_pkg::CH_SLASH
                                                                : held_char;
        res0.token_kind     = ttl_pkg::KIND_BARE;
        res0.first_of_token = (lex_mode == ttl_pkg::MODE_SLASH) ? 1'b1 : held_is_first;
        res0.last_of_token  = 1'b1;
        res1.is_status      = 1'b1;
        res1.end_status     = ttl_pkg::END_CLEAN;
        res_cnt             = 2'd2;
      end else begin
        res0.is_status  = 1'b1;
        res0.end_status = (lex_mode == ttl_pkg::MODE_QUOTED) ? ttl_pkg::END_UNTERMINATED
                                                             : ttl_pkg::END_CLEAN;
        res_cnt         = 2'd1;
      end
      lex_mode_next       = ttl_pkg::MODE_BETWEEN;
      held_char_next      = '0;
      held_is_first_next  = 1'b0;
      star_seen_next      = 1'b0;
      escape_pending_next = 1'b0;
    end else begin
      case (lex_mode)
        ttl_pkg::MODE_SLASH: begin
          if (c == ttl_pkg::CH_SLASH) begin
            lex_mode_next = ttl_pkg::MODE_LINE;
          end else if (c == ttl_pkg::CH_STAR) begin
            star_seen_next = 1'b0;
            lex_mode_next  = ttl_pkg::MODE_BLOCK;
          end else begin
            // lone slash starts a bare word
            lex_mode_next = ttl_pkg::MODE_BARE;
            bare_hc       = ttl_pkg::CH_SLASH;
            bare_hf       = 1'b1;
            do_bare       = 1'b1;
          end
        end
        ttl_pkg::MODE_LINE: begin
          if (c == ttl_pkg::CH_NL) begin
            lex_mode_next = ttl_pkg::MODE_BETWEEN;
          end
        end
        ttl_pkg::MODE_BLOCK: begin
          if (star_seen && c == ttl_pkg::CH_SLASH) begin
            star_seen_next = 1'b0;
            lex_mode_next  = ttl_pkg::MODE_BETWEEN;
          end else begin
            star_seen_next = (c == ttl_pkg::CH_STAR);
          end
        end
        ttl_pkg::MODE_BARE: begin
          do_bare = 1'b1;
        end
        ttl_pkg::MODE_QUOTED: begin
          res0.out_byte   = c;
          res0.token_kind = ttl_pkg::KIND_QUOTED;
          res_cnt         = 2'd1;
          if (escape_pending) begin
            escape_pending_next = 1'b0;
          end else if (c == ttl_pkg::CH_QUOTE) begin
            res0.last_of_token = 1'b1;
            lex_mode_next      = ttl_pkg::MODE_BETWEEN;
          end else if (c == ttl_pkg::CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end
        end
        default: begin
          // between tokens, also unused mode codes
          lex_mode_next = ttl_pkg::MODE_BETWEEN;
          if (c_space) begin
          end else if (c == ttl_pkg::CH_SLASH) begin
            lex_mode_next = ttl_pkg::MODE_SLASH;
          end else if (c_brace) begin
            res0.out_byte       = c;
            res0.token_kind     = ttl_pkg::KIND_BRACE;
            res0.first_of_token = 1'b1;
            res0.last_of_token  = 1'b1;
            res_cnt             = 2'd1;
          end else if (c == ttl_pkg::CH_QUOTE) begin
            res0.out_byte       = c;
            res0.token_kind     = ttl_pkg::KIND_QUOTED;
            res0.first_of_token = 1'b1;
            res_cnt             = 2'd1;
            escape_pending_next = 1'b0;
            lex_mode_next       = ttl_pkg::MODE_QUOTED;
          end else begin
            held_char_next     = c;
            held_is_first_next = 1'b1;
            lex_mode_next      = ttl_pkg::MODE_BARE;
          end
        end
      endcase

      // bare word byte: emit the held character, hold or end
      if (do_bare) begin
        res0.out_byte       = bare_hc;
        res0.token_kind     = ttl_pkg::KIND_BARE;
        res0.first_of_token = bare_hf;
        res_cnt             = 2'd1;
        held_is_first_next  = 1'b0;
        if (c_space || c_brace) begin
          res0.last_of_token = 1'b1;
          held_char_next     = '0;
          lex_mode_next      = ttl_pkg::MODE_BETWEEN;
          if (c_brace) begin
            res1.out_byte       = c;
            res1.token_kind     = ttl_pkg::KIND_BRACE;
            res1.first_of_token = 1'b1;
            res1.last_of_token  = 1'b1;
            res_cnt             = 2'd2;
          end
        end else begin
          held_char_next = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= ttl_pkg::MODE_BETWEEN;
      held_char      <= '0;
      held_is_first  <= 1'b0;
      star_seen      <= 1'b0;
      escape_pending <= 1'b0;
    end else if (take) begin
      lex_mode       <= lex_mode_next;
      held_char      <= held_char_next;
      held_is_first  <= held_is_first_next;
      star_seen      <= star_seen_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ttl_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_resq
// small result queue taking up to two beats a cycle and giving one unless stalled
// ----------------------------------------------------------------------------
module ttl_resq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         push_cnt,
  input  wire ttl_pkg::out_beat_t push0,
  input  wire ttl_pkg::out_beat_t push1,
  output logic                    room,
  output logic                    valid,
  input  wire logic               stall,
  output ttl_pkg::out_beat_t      data
);

  localparam logic [ttl_pkg::QCNT_W-1:0] ROOM_MAX =
    ttl_pkg::QCNT_W'(ttl_pkg::QDEPTH - 2);

  ttl_pkg::out_beat_t              entry [ttl_pkg::QDEPTH];
  logic [ttl_pkg::QPTR_W-1:0]      wr_ptr, wr_ptr_next;
  logic [ttl_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ttl_pkg::QCNT_W-1:0]      count, count_next;
  logic                            pop;

  assign room  = (count <= ROOM_MAX);
  assign valid = (count != '0);
  assign data  = entry[rd_ptr];
  assign pop   = valid && !stall;

  assign wr_ptr_next = wr_ptr + ttl_pkg::QPTR_W'(push_cnt);
  assign count_next  = count + ttl_pkg::QCNT_W'(push_cnt) - ttl_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + ttl_pkg::QPTR_W'(1);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      entry[wr_ptr + ttl_pkg::QPTR_W'(1)] <= push1;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/text_token_lexer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_token_lexer_core
// byte-stream lexer emitting token characters with kind and boundary marks
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle while byte_stall is low. Whitespace, line
// comments and block comments between tokens are dropped; token characters
// come out one per result beat, marked first/last and tagged bare word,
// brace or quoted string. A bare word's characters leave one byte late,
// since its last character is only known once a delimiter shows up. An
// end-of-input beat flushes any held character and then gives a status
// beat (clean, or unterminated string), after which the lexer is back in
// its reset state. Each input beat is handled in the cycle it is accepted
// and gives zero, one or two result beats; results go into a four-entry
// queue that drains one beat per cycle while tok_stall is low, so the input
// takes a beat every cycle as long as the queue holds at most two beats. A
// brace directly after a bare word, or an end marker after a held character,
// yields two results. Result beats are registered in the queue.
// ----------------------------------------------------------------------------
module text_token_lexer_core (
  input  wire logic               clk,
  input  wire logic               rst,
  // character beats
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire ttl_pkg::in_beat_t  byte_beat,
  // token / status beats
  output logic                    tok_valid,
  input  wire logic               tok_stall,
  output ttl_pkg::out_beat_t      tok_beat
);

  logic               take;
  logic               room;
  logic [1:0]         res_cnt;
  logic [1:0]         push_cnt;
  ttl_pkg::out_beat_t res0;
  ttl_pkg::out_beat_t res1;

  // stall only from registered queue fill, never from tok_stall directly
  assign byte_stall = !room;
  assign take       = byte_valid && room;
  assign push_cnt   = take ? res_cnt : 2'd0;

  // lexer state and per-byte decode
  ttl_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .beat    (byte_beat),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // result queue acts as the output register
  ttl_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .valid    (tok_valid),
    .stall    (tok_stall),
    .data     (tok_beat)
  );

endmodule
`default_nettype wire

>>> tb/tb_text_token_lexer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_text_token_lexer_core
// self-checking bench for the byte-stream token lexer
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes runs first: reset state, braces, comment
// openers and closers, lone slash, quotes, escapes and end markers. Some rows
// carry their results typed in, and the rest are checked against a
// cycle-free lexer model kept in this bench. Random text follows: whitespace,
// comments, words, strings, braces and end markers, with some broken
// sequences and raw noise mixed in. The sender bursts and pauses, the
// receiver stalls on its own pattern, and one long receiver hold-off and one
// full drain are forced.
// ----------------------------------------------------------------------------
module tb_text_token_lexer_core;

  // a bench row: one input beat, plus optional hand-typed results
  typedef struct packed {
    logic [7:0]         ch;
    logic               eoi;
    logic               typed;
    logic [1:0]         n;
    ttl_pkg::out_beat_t r0;
    ttl_pkg::out_beat_t r1;
  } feed_row_t;

  localparam int unsigned DIR_N       = 26;
  localparam int unsigned RAND_N      = 825;
  localparam int unsigned DRAIN_AT    = 300;     // row index where the sender drains
  localparam int unsigned HOLD_AFTER  = 500;     // accepted beats before the hold-off
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_SHOWN   = 10;

  localparam logic HAND = 1'b1;
  localparam logic PRED = 1'b0;

  // hand-typed results
  localparam ttl_pkg::out_beat_t NO_TOK    = '0;
  localparam ttl_pkg::out_beat_t ST_CLEAN  = '{
    8'h00, ttl_pkg::KIND_BARE, 1'b0, 1'b0, 1'b1, ttl_pkg::END_CLEAN};
  localparam ttl_pkg::out_beat_t ST_UNTERM = '{
    8'h00, ttl_pkg::KIND_BARE, 1'b0, 1'b0, 1'b1, ttl_pkg::END_UNTERMINATED};
  localparam ttl_pkg::out_beat_t LB_TOK    = '{
    ttl_pkg::CH_LBRACE, ttl_pkg::KIND_BRACE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN};
  localparam ttl_pkg::out_beat_t RB_TOK    = '{
    ttl_pkg::CH_RBRACE, ttl_pkg::KIND_BRACE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN};
  localparam ttl_pkg::out_beat_t A_TOK     = '{
    8'h61, ttl_pkg::KIND_BARE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN};
  localparam ttl_pkg::out_beat_t NUL_TOK   = '{
    8'h00, ttl_pkg::KIND_BARE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN};
  localparam ttl_pkg::out_beat_t SL_TOK    = '{
    ttl_pkg::CH_SLASH, ttl_pkg::KIND_BARE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN};

  localparam logic [7:0] BLANKS [6] = '{
    ttl_pkg::CH_SPACE, ttl_pkg::CH_TAB, ttl_pkg::CH_NL,
    ttl_pkg::CH_VT, ttl_pkg::CH_FF, ttl_pkg::CH_CR};

  // directed table
  localparam feed_row_t DIR_TBL [DIR_N] = '{
    '{8'h00,              1'b1, HAND, 2'd1, ST_CLEAN, NO_TOK},  // end marker after reset
    '{ttl_pkg::CH_LBRACE, 1'b0, HAND, 2'd1, LB_TOK, NO_TOK},    // lone brace token
    '{8'h61,              1'b0, HAND, 2'd0, NO_TOK, NO_TOK},    // word char is held back
    '{ttl_pkg::CH_RBRACE, 1'b0, HAND, 2'd2, A_TOK, RB_TOK},     // brace flushes the word
    '{ttl_pkg::CH_SLASH,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // line comment opener
    '{ttl_pkg::CH_SLASH,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},
    '{8'hFF,              1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // top byte swallowed
    '{ttl_pkg::CH_NL,     1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // newline ends the comment
    '{ttl_pkg::CH_SLASH,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // block comment opener
    '{ttl_pkg::CH_STAR,   1'b0, PRED, 2'd0, NO_TOK, NO_TOK},
    '{ttl_pkg::CH_SLASH,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // opener star must not close
    '{ttl_pkg::CH_STAR,   1'b0, PRED, 2'd0, NO_TOK, NO_TOK},
    '{ttl_pkg::CH_SLASH,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // real close
    '{ttl_pkg::CH_SLASH,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // lone slash starts a word
    '{8'h78,              1'b0, PRED, 2'd0, NO_TOK, NO_TOK},
    '{ttl_pkg::CH_QUOTE,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // quote inside a word
    '{ttl_pkg::CH_VT,     1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // vertical tab is blank
    '{ttl_pkg::CH_QUOTE,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // string opens
    '{ttl_pkg::CH_BSLASH, 1'b0, PRED, 2'd0, NO_TOK, NO_TOK},
    '{ttl_pkg::CH_QUOTE,  1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // protected quote
    '{8'h80,              1'b0, PRED, 2'd0, NO_TOK, NO_TOK},    // high byte is not blank
    '{8'hA5,              1'b1, HAND, 2'd1, ST_UNTERM, NO_TOK}, // cut-off string
    '{8'h00,              1'b0, HAND, 2'd0, NO_TOK, NO_TOK},    // nul starts a word
    '{8'h5A,              1'b1, HAND, 2'd2, NUL_TOK, ST_CLEAN}, // flush held char, then status
    '{ttl_pkg::CH_SLASH,  1'b0, HAND, 2'd0, NO_TOK, NO_TOK},
    '{8'hFF,              1'b1, HAND, 2'd2, SL_TOK, ST_CLEAN}   // pending slash is a word
  };

  logic               clk;
  logic               rst;
  logic               byte_valid;
  logic               byte_stall;
  ttl_pkg::in_beat_t  byte_beat;
  logic               tok_valid;
  logic               tok_stall;
  ttl_pkg::out_beat_t tok_beat;

  text_token_lexer_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_beat  (byte_beat),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_beat   (tok_beat)
  );

  feed_row_t          feed_q [$];     // everything the sender will offer
  feed_row_t          offered_q [$];  // rows offered but not yet accepted
  ttl_pkg::out_beat_t token_q [$];    // results still owed by the block
  ttl_pkg::out_beat_t fresh_q [$];    // results of the beat being modeled
  int unsigned        taken_cnt = 0;
  int unsigned        fault_cnt = 0;
  int unsigned        cycles = 0;

  // lexer model state
  ttl_pkg::lex_mode_t lx_mode       = ttl_pkg::MODE_BETWEEN;
  logic [7:0]         lx_held       = 8'h00;
  logic               lx_held_first = 1'b0;
  logic               lx_star       = 1'b0;
  logic               lx_esc        = 1'b0;

  function automatic logic is_blank(logic [7:0] c);
    return c == ttl_pkg::CH_SPACE || c == ttl_pkg::CH_TAB || c == ttl_pkg::CH_NL ||
           c == ttl_pkg::CH_VT || c == ttl_pkg::CH_FF || c == ttl_pkg::CH_CR;
  endfunction

  function automatic logic is_brace(logic [7:0] c);
    return c == ttl_pkg::CH_LBRACE || c == ttl_pkg::CH_RBRACE;
  endfunction

  function automatic void note(logic [7:0] ch, logic [1:0] kind, logic first, logic last,
                               logic st, logic code);
    ttl_pkg::out_beat_t t;
    t.out_byte       = ch;
    t.token_kind     = kind;
    t.first_of_token = first;
    t.last_of_token  = last;
    t.is_status      = st;
    t.end_status     = code;
    fresh_q.insert(fresh_q.size(), t);
  endfunction

  // one byte while a bare word is open: emit the held char, then hold the new one or end the word
  function automatic void bare_step(logic [7:0] c);
    if (is_blank(c) || is_brace(c)) begin
      note(lx_held, ttl_pkg::KIND_BARE, lx_held_first, 1'b1, 1'b0, ttl_pkg::END_CLEAN);
      lx_held       = 8'h00;
      lx_held_first = 1'b0;
      lx_mode       = ttl_pkg::MODE_BETWEEN;
      if (is_brace(c)) note(c, ttl_pkg::KIND_BRACE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN);
    end else begin
      note(lx_held, ttl_pkg::KIND_BARE, lx_held_first, 1'b0, 1'b0, ttl_pkg::END_CLEAN);
      lx_held       = c;
      lx_held_first = 1'b0;
    end
  endfunction

  // token characters and status that one input beat produces
  function automatic void lex_predict(ttl_pkg::in_beat_t b);
    logic [7:0] c;
    logic       code;
    c = b.in_byte;
    if (b.end_of_input) begin
      code = ttl_pkg::END_CLEAN;
      if (lx_mode == ttl_pkg::MODE_SLASH)
        note(ttl_pkg::CH_SLASH, ttl_pkg::KIND_BARE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN);
      else if (lx_mode == ttl_pkg::MODE_BARE)
        note(lx_held, ttl_pkg::KIND_BARE, lx_held_first, 1'b1, 1'b0, ttl_pkg::END_CLEAN);
      else if (lx_mode == ttl_pkg::MODE_QUOTED) code = ttl_pkg::END_UNTERMINATED;
      note(8'h00, ttl_pkg::KIND_BARE, 1'b0, 1'b0, 1'b1, code);
      lx_mode       = ttl_pkg::MODE_BETWEEN;
      lx_held       = 8'h00;
      lx_held_first = 1'b0;
      lx_star       = 1'b0;
      lx_esc        = 1'b0;
      return;
    end
    case (lx_mode)
      ttl_pkg::MODE_SLASH: begin
        if (c == ttl_pkg::CH_SLASH) lx_mode = ttl_pkg::MODE_LINE;
        else if (c == ttl_pkg::CH_STAR) begin
          lx_star = 1'b0;
          lx_mode = ttl_pkg::MODE_BLOCK;
        end else begin
          // lone slash becomes the first char of a word
          lx_held       = ttl_pkg::CH_SLASH;
          lx_held_first = 1'b1;
          lx_mode       = ttl_pkg::MODE_BARE;
          bare_step(c);
        end
      end
      ttl_pkg::MODE_LINE: begin
        if (c == ttl_pkg::CH_NL) lx_mode = ttl_pkg::MODE_BETWEEN;
      end
      ttl_pkg::MODE_BLOCK: begin
        if (lx_star && c == ttl_pkg::CH_SLASH) begin
          lx_star = 1'b0;
          lx_mode = ttl_pkg::MODE_BETWEEN;
        end else begin
          lx_star = (c == ttl_pkg::CH_STAR);
        end
      end
      ttl_pkg::MODE_BARE: bare_step(c);
      ttl_pkg::MODE_QUOTED: begin
        if (lx_esc) begin
          lx_esc = 1'b0;
          note(c, ttl_pkg::KIND_QUOTED, 1'b0, 1'b0, 1'b0, ttl_pkg::END_CLEAN);
        end else if (c == ttl_pkg::CH_QUOTE) begin
          note(c, ttl_pkg::KIND_QUOTED, 1'b0, 1'b1, 1'b0, ttl_pkg::END_CLEAN);
          lx_mode = ttl_pkg::MODE_BETWEEN;
        end else begin
          if (c == ttl_pkg::CH_BSLASH) lx_esc = 1'b1;
          note(c, ttl_pkg::KIND_QUOTED, 1'b0, 1'b0, 1'b0, ttl_pkg::END_CLEAN);
        end
      end
      default: begin
        lx_mode = ttl_pkg::MODE_BETWEEN;
        if (is_blank(c)) begin
        end else if (c == ttl_pkg::CH_SLASH) begin
          lx_mode = ttl_pkg::MODE_SLASH;
        end else if (is_brace(c)) begin
          note(c, ttl_pkg::KIND_BRACE, 1'b1, 1'b1, 1'b0, ttl_pkg::END_CLEAN);
        end else if (c == ttl_pkg::CH_QUOTE) begin
          note(c, ttl_pkg::KIND_QUOTED, 1'b1, 1'b0, 1'b0, ttl_pkg::END_CLEAN);
          lx_esc  = 1'b0;
          lx_mode = ttl_pkg::MODE_QUOTED;
        end else begin
          lx_held       = c;
          lx_held_first = 1'b1;
          lx_mode       = ttl_pkg::MODE_BARE;
        end
      end
    endcase
  endfunction

  function automatic void report_fault(string what, ttl_pkg::out_beat_t want,
                                       ttl_pkg::out_beat_t got);
    fault_cnt++;
    if (fault_cnt <= MAX_SHOWN) begin
      $display("%s: want byte %h kind %0d first %b last %b st %b code %b",
               what, want.out_byte, want.token_kind, want.first_of_token,
               want.last_of_token, want.is_status, want.end_status);
      $display("%s:  got byte %h kind %0d first %b last %b st %b code %b",
               what, got.out_byte, got.token_kind, got.first_of_token,
               got.last_of_token, got.is_status, got.end_status);
    end
  endfunction

  function automatic void queue_char(logic [7:0] c, logic eoi);
    feed_q.insert(feed_q.size(), feed_row_t'{c, eoi, PRED, 2'd0, NO_TOK, NO_TOK});
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset, once, at the start
  initial begin
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL text_token_lexer_core");
    $finish;
  end

  // result checking and input-side modeling, both sampled at the edge
  always @(posedge clk) begin
    feed_row_t          row;
    ttl_pkg::out_beat_t want;
    if (!rst) begin
      // result beat
      if (tok_valid && !tok_stall) begin
        if (token_q.size() == 0) begin
          report_fault("unexpected result", NO_TOK, tok_beat);
        end else begin
          want = token_q.pop_front();
          if (tok_beat.out_byte !== want.out_byte ||
              tok_beat.token_kind !== want.token_kind ||
              tok_beat.first_of_token !== want.first_of_token ||
              tok_beat.last_of_token !== want.last_of_token ||
              tok_beat.is_status !== want.is_status ||
              tok_beat.end_status !== want.end_status)
            report_fault("result mismatch", want, tok_beat);
        end
      end
      // input beat: model it, then owe either the typed or the modeled results
      if (byte_valid && !byte_stall) begin
        row = offered_q.pop_front();
        taken_cnt++;
        fresh_q.delete();
        lex_predict(byte_beat);
        if (row.typed) begin
          if (row.n > 0) token_q.insert(token_q.size(), row.r0);
          if (row.n > 1) token_q.insert(token_q.size(), row.r1);
        end else begin
          foreach (fresh_q[i]) token_q.insert(token_q.size(), fresh_q[i]);
        end
      end
    end
  end

  // receiver: phases of stall patterns, plus one long hold-off mid-run
  initial begin
    int unsigned phase;
    int unsigned phase_left;
    logic        hold_done;
    phase      = 0;
    phase_left = 0;
    hold_done  = 1'b0;
    tok_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && taken_cnt >= HOLD_AFTER) begin
        // block the output long enough for the queue to fill and stall input
        hold_done = 1'b1;
        tok_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 3);
        phase_left = $urandom_range(5, 60);
      end
      phase_left--;
      case (phase)
        0: tok_stall <= 1'b0;                          // free-running stretch
        1: tok_stall <= ($urandom_range(0, 3) == 0);   // light stalls
        2: tok_stall <= ($urandom_range(0, 3) != 0);   // heavy stalls
        default: tok_stall <= ~tok_stall;              // alternate every beat
      endcase
      @(posedge clk);
    end
  end

  // sender: builds the text, then offers it in bursts
  initial begin
    int unsigned seg;
    int unsigned len;
    int unsigned pick;
    int unsigned gap;
    int unsigned burst_left;
    int unsigned idx;
    logic [7:0]  c;
    feed_row_t   row;

    byte_valid <= 1'b0;
    byte_beat  <= '0;

    foreach (DIR_TBL[i]) feed_q.insert(feed_q.size(), DIR_TBL[i]);

    // random text: mostly well-formed pieces, some broken ones and noise
    while (feed_q.size() < DIR_N + RAND_N) begin
      seg = $urandom_range(0, 19);
      if (seg < 4) begin
        // blank run
        len = $urandom_range(1, 3);
        repeat (len) queue_char(BLANKS[$urandom_range(0, 5)], 1'b0);
      end else if (seg < 6) begin
        // line comment, newline sometimes missing
        queue_char(ttl_pkg::CH_SLASH, 1'b0);
        queue_char(ttl_pkg::CH_SLASH, 1'b0);
        len = $urandom_range(0, 6);
        repeat (len) queue_char(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 7) != 0) queue_char(ttl_pkg::CH_NL, 1'b0);
      end else if (seg < 8) begin
        // block comment with stars and slashes inside, closer sometimes missing
        queue_char(ttl_pkg::CH_SLASH, 1'b0);
        queue_char(ttl_pkg::CH_STAR, 1'b0);
        len = $urandom_range(0, 6);
        repeat (len) begin
          pick = $urandom_range(0, 3);
          if (pick == 0) queue_char(ttl_pkg::CH_STAR, 1'b0);
          else if (pick == 1) queue_char(ttl_pkg::CH_SLASH, 1'b0);
          else queue_char(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 7) != 0) begin
          queue_char(ttl_pkg::CH_STAR, 1'b0);
          queue_char(ttl_pkg::CH_SLASH, 1'b0);
        end
      end else if (seg < 12) begin
        // bare word, then blank, brace or nothing
        len = $urandom_range(1, 6);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
          else c = 8'(8'h61 + $urandom_range(0, 25));
          queue_char(c, 1'b0);
        end
        pick = $urandom_range(0, 3);
        if (pick < 2) queue_char(BLANKS[$urandom_range(0, 5)], 1'b0);
        else if (pick == 2)
          queue_char($urandom_range(0, 1) ? ttl_pkg::CH_LBRACE : ttl_pkg::CH_RBRACE, 1'b0);
      end else if (seg < 15) begin
        // quoted string with escapes, closing quote sometimes missing
        queue_char(ttl_pkg::CH_QUOTE, 1'b0);
        len = $urandom_range(0, 8);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) begin
            queue_char(ttl_pkg::CH_BSLASH, 1'b0);
            queue_char(8'($urandom_range(0, 255)), 1'b0);
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == ttl_pkg::CH_QUOTE) c = ttl_pkg::CH_BSLASH;
            queue_char(c, 1'b0);
          end
        end
        if ($urandom_range(0, 7) != 0) queue_char(ttl_pkg::CH_QUOTE, 1'b0);
      end else if (seg < 17) begin
        queue_char($urandom_range(0, 1) ? ttl_pkg::CH_LBRACE : ttl_pkg::CH_RBRACE, 1'b0);
      end else if (seg == 17) begin
        // end marker; its byte is junk
        queue_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // raw noise
        len = $urandom_range(1, 3);
        repeat (len) queue_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    @(posedge clk);
    while (rst) @(posedge clk);

    burst_left = 0;
    for (idx = 0; idx < feed_q.size(); idx++) begin
      row = feed_q[idx];
      if (idx == DRAIN_AT) begin
        // hold back until every owed result has drained
        byte_valid <= 1'b0;
        @(posedge clk);
        while (offered_q.size() != 0 || token_q.size() != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          byte_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      byte_valid <= 1'b1;
      byte_beat  <= '{row.ch, row.eoi};
      offered_q.insert(offered_q.size(), row);
      @(posedge clk);
      while (byte_stall) @(posedge clk);
    end
    byte_valid <= 1'b0;

    // wait for every owed result, then idle a tail of TAIL_CYCLES to catch strays
    while (offered_q.size() != 0 || token_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_cnt == 0 && token_q.size() == 0)
      $display("PASS text_token_lexer_core");
    else
      $display("FAIL text_token_lexer_core");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/ttl_pkg.sv
hw/rtl/ttl_step.sv
hw/rtl/ttl_resq.sv
hw/rtl/text_token_lexer_core.sv
tb/tb_text_token_lexer_core.sv
